FILE: hdl/sbq_pkg.sv
// Shared types, constants and codes for the stereo biquad filter.
`timescale 1ns / 1ps

package sbq_pkg;

  // Fixed formats of the channel payloads and the coefficient registers.
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int STATE_BITS     = 48;
  // Accumulator width: a rounded product stays within 2^43 in magnitude, so
  // the sum of two products and one delay value fits with margin.
  localparam int ACC_BITS       = STATE_BITS + 2;

  // Configuration port geometry.
  localparam int NUM_REGS  = 5;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One input item.
  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    block_end;
  } in_t;

  // One result item.
  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    logic    block_end_out;
  } out_t;

  // The shared coefficient set.
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Steps of one channel's pass through the shared multiplier.
  typedef enum logic [3:0] {
    S_B0X = 4'd0,
    S_B1X = 4'd1,
    S_B2X = 4'd2,
    S_OUT = 4'd3,
    S_A1Y = 4'd4,
    S_A2Y = 4'd5,
    S_FB1 = 4'd6,
    S_D1  = 4'd7,
    S_D2  = 4'd8
  } step_t;

  // Operand pair fed to the multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_B0X,
    MUL_B1X,
    MUL_B2X,
    MUL_A1Y,
    MUL_A2Y
  } mul_op_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_D1,
    ACC_LOAD_D2,
    ACC_ADD
  } acc_op_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic    ch;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    y_en;
    logic    d2_load;
    logic    d1_sat;
    logic    d2_sat;
  } ctl_t;

endpackage

FILE: hdl/sbq_regs.sv
// APB-style coefficient register file for the stereo biquad filter.
`timescale 1ns / 1ps

module sbq_regs #(
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbq_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [sbq_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sbq_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready,
  output sbq_pkg::coef_set_t                  coefs
);

  // Unity gain in the coefficient format.
  localparam sbq_pkg::coef_t B0_RESET = sbq_pkg::coef_t'(1) << COEF_FRAC_BITS;

  sbq_pkg::coef_set_t coefs_r;
  sbq_pkg::coef_set_t coefs_nxt;
  sbq_pkg::reg_idx_t  idx;
  logic               wr_en;

  assign idx    = sbq_pkg::reg_idx_t'(paddr[sbq_pkg::ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign coefs  = coefs_r;

  // Register write decode; addresses past the list are ignored.
  always_comb begin
    coefs_nxt = coefs_r;
    if (wr_en) begin
      unique case (idx)
        sbq_pkg::REG_B0: coefs_nxt.b0 = pwdata;
        sbq_pkg::REG_B1: coefs_nxt.b1 = pwdata;
        sbq_pkg::REG_B2: coefs_nxt.b2 = pwdata;
        sbq_pkg::REG_A1: coefs_nxt.a1 = pwdata;
        sbq_pkg::REG_A2: coefs_nxt.a2 = pwdata;
        default: ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      sbq_pkg::REG_B0: prdata = coefs_r.b0;
      sbq_pkg::REG_B1: prdata = coefs_r.b1;
      sbq_pkg::REG_B2: prdata = coefs_r.b2;
      sbq_pkg::REG_A1: prdata = coefs_r.a1;
      sbq_pkg::REG_A2: prdata = coefs_r.a2;
      default:         prdata = '0;
    endcase
  end

  // Coefficients reset to a pass-through filter: b0 is one, the rest zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r <= '{b0: B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0};
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

endmodule

FILE: hdl/sbq_mac.sv
// Shared multiply, round and accumulate datapath with the filter delay state.
`timescale 1ns / 1ps

module sbq_mac #(
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sbq_pkg::ctl_t      ctl,
  input  sbq_pkg::coef_set_t coefs,
  input  sbq_pkg::sample_t   x_left,
  input  sbq_pkg::sample_t   x_right,
  output sbq_pkg::sample_t   y_left,
  output sbq_pkg::sample_t   y_right
);

  localparam int SB         = sbq_pkg::SAMPLE_BITS;
  localparam int AW         = sbq_pkg::ACC_BITS;
  localparam int STW        = sbq_pkg::STATE_BITS;
  localparam int PROD_W     = SB + sbq_pkg::COEF_BITS;
  localparam int PROD_SHIFT = SB - 13;
  localparam int OUT_SHIFT  = COEF_FRAC_BITS + 13 - SB;
  localparam int RND_W      = (PROD_W + 1 > AW) ? PROD_W + 1 : AW;

  localparam logic signed [RND_W-1:0] PROD_HALF = RND_W'(1) << (PROD_SHIFT - 1);

  localparam logic signed [AW-1:0] ST_MAX = {{(AW-STW+1){1'b0}}, {(STW-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN = {{(AW-STW+1){1'b1}}, {(STW-1){1'b0}}};
  localparam logic signed [AW:0]   SM_MAX = {{(AW-SB+2){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW:0]   SM_MIN = {{(AW-SB+2){1'b1}}, {(SB-1){1'b0}}};

  // Saturate a wide value to the sample range.
  function automatic sbq_pkg::sample_t sat_out(input logic signed [AW:0] v);
    logic signed [AW:0] c;
    c = v;
    if (v > SM_MAX) c = SM_MAX;
    if (v < SM_MIN) c = SM_MIN;
    return c[SB-1:0];
  endfunction

  sbq_pkg::coef_t          mul_coef;
  sbq_pkg::sample_t        mul_opnd;
  sbq_pkg::sample_t        x_sel;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [RND_W-1:0]  rnd_ext, rnd_sum, rnd_sh;
  logic signed [AW-1:0]     rnd_r, rnd_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt, acc_opa;
  logic signed [STW-1:0]    state_sat;
  sbq_pkg::sample_t         y_conv;
  sbq_pkg::sample_t         y_r [2];
  logic signed [STW-1:0]    d1_r [2];
  logic signed [STW-1:0]    d2_r [2];
  logic signed [STW-1:0]    d1_nxt, d2_nxt;

  assign x_sel   = ctl.ch ? x_right : x_left;
  assign y_left  = y_r[0];
  assign y_right = y_r[1];

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctl.mul_op)
      sbq_pkg::MUL_B0X: begin mul_coef = coefs.b0; mul_opnd = x_sel;       end
      sbq_pkg::MUL_B1X: begin mul_coef = coefs.b1; mul_opnd = x_sel;       end
      sbq_pkg::MUL_B2X: begin mul_coef = coefs.b2; mul_opnd = x_sel;       end
      sbq_pkg::MUL_A1Y: begin mul_coef = coefs.a1; mul_opnd = y_r[ctl.ch]; end
      sbq_pkg::MUL_A2Y: begin mul_coef = coefs.a2; mul_opnd = y_r[ctl.ch]; end
      default:          begin mul_coef = '0;       mul_opnd = '0;          end
    endcase
  end

  assign prod_nxt = (ctl.mul_op == sbq_pkg::MUL_NONE) ? prod_r : mul_coef * mul_opnd;

  // Round each product half up to the state format.
  assign rnd_ext = RND_W'(prod_r);
  assign rnd_sum = rnd_ext + PROD_HALF;
  assign rnd_sh  = rnd_sum >>> PROD_SHIFT;
  assign rnd_nxt = rnd_sh[AW-1:0];

  // Single accumulator adder: rounded product plus a delay value or the sum.
  always_comb begin
    unique case (ctl.acc_op)
      sbq_pkg::ACC_LOAD_D1: acc_opa = AW'(d1_r[ctl.ch]);
      sbq_pkg::ACC_LOAD_D2: acc_opa = AW'(d2_r[ctl.ch]);
      default:              acc_opa = acc_r;
    endcase
    acc_nxt = (ctl.acc_op == sbq_pkg::ACC_HOLD) ? acc_r : acc_opa + rnd_r;
  end

  // Saturation of a new delay value.
  always_comb begin
    state_sat = acc_r[STW-1:0];
    if (acc_r > ST_MAX) state_sat = ST_MAX[STW-1:0];
    if (acc_r < ST_MIN) state_sat = ST_MIN[STW-1:0];
  end

  // Conversion of the accumulator to an output sample.
  generate
    if (OUT_SHIFT > 0) begin : g_out_rnd
      localparam logic signed [AW:0] OUT_HALF = (AW + 1)'(1) << (OUT_SHIFT - 1);
      logic signed [AW:0] o_sum;
      logic signed [AW:0] o_sh;
      assign o_sum  = (AW + 1)'(acc_r) + OUT_HALF;
      assign o_sh   = o_sum >>> OUT_SHIFT;
      assign y_conv = sat_out(o_sh);
    end else if (OUT_SHIFT == 0) begin : g_out_eq
      assign y_conv = sat_out((AW + 1)'(acc_r));
    end else begin : g_out_lsh
      localparam int LSH = -OUT_SHIFT;
      sbq_pkg::sample_t   y0;
      logic signed [AW:0] ysh;
      assign y0     = sat_out((AW + 1)'(acc_r));
      assign ysh    = (AW + 1)'(y0) <<< LSH;
      assign y_conv = sat_out(ysh);
    end
  endgenerate

  // Next delay values for the channel at work.
  always_comb begin
    d1_nxt = d1_r[ctl.ch];
    d2_nxt = d2_r[ctl.ch];
    if (ctl.d1_sat)  d1_nxt = state_sat;
    if (ctl.d2_load) d2_nxt = rnd_r[STW-1:0];
    if (ctl.d2_sat)  d2_nxt = state_sat;
  end

  // Datapath pipeline registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rnd_r  <= rnd_nxt;
    acc_r  <= acc_nxt;
    if (ctl.y_en) begin
      y_r[ctl.ch] <= y_conv;
    end
  end

  // Filter delay state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r[0] <= '0;
      d1_r[1] <= '0;
      d2_r[0] <= '0;
      d2_r[1] <= '0;
    end else begin
      d1_r[ctl.ch] <= d1_nxt;
      d2_r[ctl.ch] <= d2_nxt;
    end
  end

endmodule

FILE: hdl/stereo_biquad_filter.sv
// Top level of the stereo biquad filter: handshakes, sequencer and result register.
//
//   Channel | Ports                                      | Payload
//   --------+--------------------------------------------+---------------------
//   input   | in_valid, in_ready, in_data                | sbq_pkg::in_t
//   result  | out_valid, out_ready, out_data             | sbq_pkg::out_t
//   config  | psel, penable, pwrite, paddr, pwdata,      | five Q3.28 coefs
//           | prdata, pready                             | at byte 4*index
//
// An item is accepted, then makes nine steps per channel (left then right)
// through the single shared multiplier, and then loads the result register. The
// feedback products wait for the rounded output sample, which sets the nine steps.
// in_ready is high only while idle. A finished item waits in the output register,
// so the next item is accepted while out_ready is low; the load waits while it is full.
// Reset clears the delay state and loads the pass-through coefficients.
`timescale 1ns / 1ps

module stereo_biquad_filter #(
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbq_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sbq_pkg::out_t                 out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbq_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sbq_pkg::DATA_BITS-1:0] pwdata,
  output logic [sbq_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  sbq_pkg::state_t    state_r, state_nxt;
  sbq_pkg::step_t     step_r, step_nxt;
  logic               ch_r, ch_nxt;
  logic               out_valid_r, out_valid_nxt;
  sbq_pkg::in_t       in_data_r, in_data_nxt;
  sbq_pkg::out_t      out_data_r, out_data_nxt;
  sbq_pkg::ctl_t      ctl;
  sbq_pkg::coef_set_t coefs;
  sbq_pkg::sample_t   y_left;
  sbq_pkg::sample_t   y_right;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sbq_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  sbq_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .coefs   (coefs),
    .x_left  (in_data_r.left_in),
    .x_right (in_data_r.right_in),
    .y_left  (y_left),
    .y_right (y_right)
  );

  // Step decode: which product enters the multiplier and what the
  // accumulator and delay registers do in each cycle of a channel pass.
  always_comb begin
    ctl        = '0;
    ctl.ch     = ch_r;
    ctl.mul_op = sbq_pkg::MUL_NONE;
    ctl.acc_op = sbq_pkg::ACC_HOLD;
    if (state_r == sbq_pkg::ST_RUN) begin
      unique case (step_r)
        sbq_pkg::S_B0X: ctl.mul_op = sbq_pkg::MUL_B0X;
        sbq_pkg::S_B1X: ctl.mul_op = sbq_pkg::MUL_B1X;
        sbq_pkg::S_B2X: begin
          ctl.mul_op = sbq_pkg::MUL_B2X;
          ctl.acc_op = sbq_pkg::ACC_LOAD_D1;
        end
        sbq_pkg::S_OUT: begin
          ctl.y_en   = 1'b1;
          ctl.acc_op = sbq_pkg::ACC_LOAD_D2;
        end
        sbq_pkg::S_A1Y: begin
          ctl.mul_op  = sbq_pkg::MUL_A1Y;
          ctl.d2_load = 1'b1;
        end
        sbq_pkg::S_A2Y: ctl.mul_op = sbq_pkg::MUL_A2Y;
        sbq_pkg::S_FB1: ctl.acc_op = sbq_pkg::ACC_ADD;
        sbq_pkg::S_D1: begin
          ctl.d1_sat = 1'b1;
          ctl.acc_op = sbq_pkg::ACC_LOAD_D2;
        end
        sbq_pkg::S_D2:  ctl.d2_sat = 1'b1;
        default: ;
      endcase
    end
  end

  // Sequencer next state and handshake outputs.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ch_nxt        = ch_r;
    in_data_nxt   = in_data_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    unique case (state_r)
      sbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_data_nxt = in_data;
          step_nxt    = sbq_pkg::S_B0X;
          ch_nxt      = 1'b0;
          state_nxt   = sbq_pkg::ST_RUN;
        end
      end
      sbq_pkg::ST_RUN: begin
        if (step_r == sbq_pkg::S_D2) begin
          step_nxt = sbq_pkg::S_B0X;
          ch_nxt   = 1'b1;
          if (ch_r) begin
            state_nxt = sbq_pkg::ST_DONE;
          end
        end else begin
          step_nxt = sbq_pkg::step_t'(step_r + 4'd1);
        end
      end
      sbq_pkg::ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.left_out      = y_left;
          out_data_nxt.right_out     = y_right;
          out_data_nxt.block_end_out = in_data_r.block_end;
          out_valid_nxt              = 1'b1;
          state_nxt                  = sbq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbq_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbq_pkg::ST_IDLE;
      step_r      <= sbq_pkg::S_B0X;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
